>>> rtl/cbop_pkg.sv
// Shared types, codes and constants of the CB-prefix bit operation unit.
package cbop_pkg;

   // Register file geometry: eight byte slots, slot 6 stands for the memory operand
   localparam int REG_W     = 8;
   localparam int REG_DEPTH = 8;
   localparam int REG_AW    = 3;
   localparam int FLAG_W    = 4;

   localparam logic [REG_AW-1:0] MEM_SLOT = 3'd6;

   // Flag bit positions inside flag_bits
   localparam int FLAG_Z_BIT = 3;
   localparam int FLAG_N_BIT = 2;
   localparam int FLAG_H_BIT = 1;
   localparam int FLAG_C_BIT = 0;

   // Item modes
   localparam logic MODE_EXEC = 1'b0;
   localparam logic MODE_LOAD = 1'b1;

   // Opcode bits 7..6
   typedef enum logic [1:0] {
      GRP_SHIFT = 2'd0,
      GRP_BIT   = 2'd1,
      GRP_RES   = 2'd2,
      GRP_SET   = 2'd3
   } group_type;

   // Opcode bits 5..3 in the shift group
   typedef enum logic [2:0] {
      SH_RLC  = 3'd0,
      SH_RRC  = 3'd1,
      SH_RL   = 3'd2,
      SH_RR   = 3'd3,
      SH_SLA  = 3'd4,
      SH_SRA  = 3'd5,
      SH_SWAP = 3'd6,
      SH_SRL  = 3'd7
   } shift_op_type;

   // One input item
   typedef struct packed {
      logic              mode;
      logic [7:0]        opcode;
      logic [REG_W-1:0]  mem_value;
      logic [REG_AW-1:0] reg_index;
      logic [REG_W-1:0]  load_value;
   } req_type;

   // One result item
   typedef struct packed {
      logic [REG_W-1:0]  result_value;
      logic [FLAG_W-1:0] flag_bits;
      logic              mem_write;
   } rsp_type;

   // Execution unit outcome: result plus the register file update
   typedef struct packed {
      rsp_type           rsp;
      logic              reg_write;
      logic [REG_AW-1:0] reg_addr;
   } alu_out_type;

endpackage

>>> rtl/cbop_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module cbop_ram #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = 8
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0]         wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [DATA_WIDTH-1:0]         rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port: hold the last read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cbop_alu.sv
// Combinational execution of one CB-prefixed opcode or register load.
module cbop_alu (
   input  cbop_pkg::req_type                  item,
   input  logic [cbop_pkg::REG_W-1:0]         reg_value,
   input  logic [cbop_pkg::FLAG_W-1:0]        flags,
   output cbop_pkg::alu_out_type              alu_out
);
   import cbop_pkg::*;

   group_type         group;
   shift_op_type      shift_op;
   logic [2:0]        bit_sel;
   logic [REG_AW-1:0] op_reg;
   logic              is_mem;
   logic [REG_W-1:0]  operand;
   logic [REG_W-1:0]  mask;
   logic [REG_W-1:0]  shifted;
   logic              carry_out;
   logic              carry_in;

   // Decode the opcode fields
   assign group    = group_type'(item.opcode[7:6]);
   assign shift_op = shift_op_type'(item.opcode[5:3]);
   assign bit_sel  = item.opcode[5:3];
   assign op_reg   = item.opcode[2:0];
   assign is_mem   = (op_reg == MEM_SLOT);
   assign operand  = is_mem ? item.mem_value : reg_value;
   assign mask     = REG_W'(1) << bit_sel;
   assign carry_in = flags[FLAG_C_BIT];

   // Rotate and shift unit
   always_comb begin
      shifted   = operand;
      carry_out = 1'b0;
      unique case (shift_op)
         SH_RLC: begin
            shifted   = {operand[REG_W-2:0], operand[REG_W-1]};
            carry_out = operand[REG_W-1];
         end
         SH_RRC: begin
            shifted   = {operand[0], operand[REG_W-1:1]};
            carry_out = operand[0];
         end
         SH_RL: begin
            shifted   = {operand[REG_W-2:0], carry_in};
            carry_out = operand[REG_W-1];
         end
         SH_RR: begin
            shifted   = {carry_in, operand[REG_W-1:1]};
            carry_out = operand[0];
         end
         SH_SLA: begin
            shifted   = {operand[REG_W-2:0], 1'b0};
            carry_out = operand[REG_W-1];
         end
         SH_SRA: begin
            shifted   = {operand[REG_W-1], operand[REG_W-1:1]};
            carry_out = operand[0];
         end
         SH_SWAP: begin
            shifted   = {operand[3:0], operand[7:4]};
            carry_out = 1'b0;
         end
         SH_SRL: begin
            shifted   = {1'b0, operand[REG_W-1:1]};
            carry_out = operand[0];
         end
         default: begin
            shifted   = operand;
            carry_out = 1'b0;
         end
      endcase
   end

   // Select the result, the new flags and the write-back target
   always_comb begin
      alu_out                  = '0;
      alu_out.rsp.flag_bits    = flags;
      if (item.mode == MODE_LOAD) begin
         alu_out.rsp.result_value = item.load_value;
         if (item.reg_index == MEM_SLOT) begin
            alu_out.rsp.flag_bits = item.load_value[7:4];
         end else begin
            alu_out.reg_write = 1'b1;
            alu_out.reg_addr  = item.reg_index;
         end
      end else begin
         unique case (group)
            GRP_SHIFT: begin
               alu_out.rsp.result_value          = shifted;
               alu_out.rsp.flag_bits             = '0;
               alu_out.rsp.flag_bits[FLAG_Z_BIT] = (shifted == '0);
               alu_out.rsp.flag_bits[FLAG_C_BIT] = carry_out;
            end
            GRP_BIT: begin
               alu_out.rsp.result_value          = operand;
               alu_out.rsp.flag_bits[FLAG_Z_BIT] = ((operand & mask) == '0);
               alu_out.rsp.flag_bits[FLAG_N_BIT] = 1'b0;
               alu_out.rsp.flag_bits[FLAG_H_BIT] = 1'b1;
            end
            GRP_RES: alu_out.rsp.result_value = operand & ~mask;
            GRP_SET: alu_out.rsp.result_value = operand | mask;
            default: alu_out.rsp.result_value = operand;
         endcase
         // BIT never writes; other groups write memory or the register
         if (group != GRP_BIT) begin
            alu_out.rsp.mem_write = is_mem;
            alu_out.reg_write     = !is_mem;
            alu_out.reg_addr      = op_reg;
         end
      end
   end

endmodule

>>> rtl/cb_prefix_bit_op_unit.sv
// Top level of the CB-prefix bit operation unit: register file RAM, execute stage, output register.
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/req_stall cbop_pkg::req_type (mode, opcode, mem_value, ...)
//   rsp_      out        rsp_valid/rsp_stall cbop_pkg::rsp_type (result_value, flag_bits, mem_write)
//
// An item can be accepted every cycle while req_stall is low; it passes the execute stage and
// then the output register before it shows on rsp_. The register file RAM is read as the item is
// accepted and written when the item leaves the execute stage; a same-cycle write to the entry being read is forwarded.
// Reset clears the per-entry valid bits (unwritten entries read as zero) and the flags.
// A stalled rsp_ side holds the output register; the execute stage still drains into it
// once, and req_stall rises only when both the execute stage and the output are full.
module cb_prefix_bit_op_unit #(
   parameter int RF_WIDTH = cbop_pkg::REG_W,
   parameter int RF_DEPTH = cbop_pkg::REG_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cbop_pkg::req_type   req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cbop_pkg::rsp_type   rsp_payload
);
   import cbop_pkg::*;

   localparam int RF_AW = $clog2(RF_DEPTH);

   logic                req_acc;
   logic                s1_adv;
   logic [RF_AW-1:0]    rd_addr;
   logic [RF_WIDTH-1:0] rd_data;
   logic                wr_en;
   logic [RF_AW-1:0]    wr_addr;
   logic [RF_WIDTH-1:0] wr_data;
   logic [REG_W-1:0]    reg_value;
   alu_out_type         alu_out;

   logic                s1_valid_ff, s1_valid_in;
   req_type             s1_item_ff;
   logic                fwd_hit_ff, fwd_hit_in;
   logic [RF_WIDTH-1:0] fwd_data_ff;
   logic                rd_valid_ff;
   logic [RF_DEPTH-1:0] reg_valid_ff, reg_valid_in;
   logic [FLAG_W-1:0]   flag_ff, flag_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_item_ff;

   // Handshake: the execute stage moves on when the output register is free
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_acc   = req_valid && !req_stall;

   // Register file access
   assign rd_addr = RF_AW'(req_payload.opcode[2:0]);
   assign wr_en   = s1_adv && alu_out.reg_write;
   assign wr_addr = RF_AW'(alu_out.reg_addr);
   assign wr_data = RF_WIDTH'(alu_out.rsp.result_value);

   cbop_ram #(
      .DATA_WIDTH (RF_WIDTH),
      .DEPTH      (RF_DEPTH)
   ) u_reg_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req_acc),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Pick the operand: forwarded write, RAM data, or zero for a never-written entry
   always_comb begin
      if (fwd_hit_ff) begin
         reg_value = REG_W'(fwd_data_ff);
      end else if (rd_valid_ff) begin
         reg_value = REG_W'(rd_data);
      end else begin
         reg_value = '0;
      end
   end

   cbop_alu u_alu (
      .item      (s1_item_ff),
      .reg_value (reg_value),
      .flags     (flag_ff),
      .alu_out   (alu_out)
   );

   // Next-state logic for control registers
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end
      fwd_hit_in   = wr_en && (wr_addr == rd_addr);
      reg_valid_in = reg_valid_ff;
      if (wr_en) begin
         reg_valid_in[wr_addr] = 1'b1;
      end
      flag_in = s1_adv ? alu_out.rsp.flag_bits : flag_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
         reg_valid_ff <= '0;
         flag_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         reg_valid_ff <= reg_valid_in;
         flag_ff      <= flag_in;
         if (req_acc) begin
            fwd_hit_ff  <= fwd_hit_in;
            rd_valid_ff <= reg_valid_ff[rd_addr];
         end
      end
   end

   // Payload registers: capture the item and forwarded data, hold the result
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_item_ff  <= req_payload;
         fwd_data_ff <= wr_data;
      end
      if (s1_adv) begin
         rsp_item_ff <= alu_out.rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

endmodule

>>> test/tb_cb_prefix_bit_op_unit.sv
// Self-checking testbench for the CB-prefix bit operation unit.
module tb_cb_prefix_bit_op_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import cbop_pkg::*;

   // Register slots as the opcode names them
   localparam logic [2:0] REG_B = 3'd0;
   localparam logic [2:0] REG_C = 3'd1;
   localparam logic [2:0] REG_D = 3'd2;
   localparam logic [2:0] REG_E = 3'd3;
   localparam logic [2:0] REG_H = 3'd4;
   localparam logic [2:0] REG_L = 3'd5;
   localparam logic [2:0] REG_A = 3'd7;

   localparam int DIRECTED_ROWS = 25;
   localparam int PHASE_ITEMS   = 467;
   localparam int HOLD_AT       = DIRECTED_ROWS + 2 * PHASE_ITEMS + 100;
   localparam int HOLD_CYCLES   = 200;
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 100000;
   localparam int REPORT_MAX    = 10;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // Shadow copy of the architectural state
   logic [REG_W-1:0]  shadow_regs [REG_DEPTH];
   logic [FLAG_W-1:0] shadow_flags;

   rsp_type      pending_results[$];
   stim_row_type directed_rows[DIRECTED_ROWS];

   int  sender_idle_pct = 16;
   int  rsp_idle_pct    = 63;
   logic hold_active = 1'b0;

   int cycle_count     = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int mismatches      = 0;
   int n_shift = 0, n_bit = 0, n_res = 0, n_set = 0;
   int n_load = 0, n_flag_load = 0, n_mem_wr = 0;

   cb_prefix_bit_op_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5ns clock = ~clock;

   // Build an opcode byte from group, op or bit number, and operand slot
   function automatic logic [7:0] cb_op(group_type grp, logic [2:0] sel, logic [2:0] slot);
      return {grp, sel, slot};
   endfunction

   function automatic req_type exec_item(logic [7:0] opc, logic [7:0] mem);
      req_type it;
      it = '0;
      it.mode = MODE_EXEC;
      it.opcode = opc;
      it.mem_value = mem;
      return it;
   endfunction

   function automatic req_type load_item(logic [2:0] idx, logic [7:0] val);
      req_type it;
      it = '0;
      it.mode = MODE_LOAD;
      it.reg_index = idx;
      it.load_value = val;
      return it;
   endfunction

   // Byte biased toward the corners that drive carry and zero flags
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h01;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic req_type random_item();
      req_type it;
      it.opcode = 8'($urandom_range(255));
      it.mem_value = pick_byte();
      it.reg_index = 3'($urandom_range(7));
      it.load_value = pick_byte();
      it.mode = ($urandom_range(99) < 25) ? MODE_LOAD : MODE_EXEC;
      return it;
   endfunction

   // Execute one item on the shadow state and return the result it produces
   function automatic rsp_type cb_step_result(req_type it);
      rsp_type      r;
      group_type    grp;
      shift_op_type sop;
      logic [2:0]   slot;
      logic         is_mem;
      logic [7:0]   opnd;
      logic [7:0]   mask;
      logic [7:0]   new_val;
      logic         carry_out;
      r = '0;
      if (it.mode == MODE_LOAD) begin
         if (it.reg_index == MEM_SLOT) shadow_flags = it.load_value[7:4];
         else shadow_regs[it.reg_index] = it.load_value;
         r.result_value = it.load_value;
      end else begin
         grp = group_type'(it.opcode[7:6]);
         sop = shift_op_type'(it.opcode[5:3]);
         slot = it.opcode[2:0];
         is_mem = (slot == MEM_SLOT);
         opnd = is_mem ? it.mem_value : shadow_regs[slot];
         mask = 8'h01 << it.opcode[5:3];
         case (grp)
            GRP_SHIFT: begin
               case (sop)
                  SH_RLC:  {carry_out, new_val} = {opnd, opnd[7]};
                  SH_RRC:  {new_val, carry_out} = {opnd[0], opnd};
                  SH_RL:   {carry_out, new_val} = {opnd, shadow_flags[FLAG_C_BIT]};
                  SH_RR:   {new_val, carry_out} = {shadow_flags[FLAG_C_BIT], opnd};
                  SH_SLA:  {carry_out, new_val} = {opnd, 1'b0};
                  SH_SRA:  {new_val, carry_out} = {opnd[7], opnd};
                  SH_SWAP: begin
                     new_val = {opnd[3:0], opnd[7:4]};
                     carry_out = 1'b0;
                  end
                  default: {new_val, carry_out} = {1'b0, opnd};
               endcase
               shadow_flags = '0;
               shadow_flags[FLAG_Z_BIT] = (new_val == 8'h00);
               shadow_flags[FLAG_C_BIT] = carry_out;
            end
            GRP_BIT: begin
               new_val = opnd;
               shadow_flags[FLAG_Z_BIT] = ((opnd & mask) == 8'h00);
               shadow_flags[FLAG_N_BIT] = 1'b0;
               shadow_flags[FLAG_H_BIT] = 1'b1;
            end
            GRP_RES: new_val = opnd & ~mask;
            default: new_val = opnd | mask;
         endcase
         // BIT writes nothing back; memory operands go out, registers stay here
         if (grp != GRP_BIT) begin
            if (is_mem) r.mem_write = 1'b1;
            else shadow_regs[slot] = new_val;
         end
         r.result_value = new_val;
      end
      r.flag_bits = shadow_flags;
      return r;
   endfunction

   // Offer one item, hold it until taken, then queue its expected result
   task automatic offer_item(req_type it, bit typed, rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = cb_step_result(it);
      pending_results.push_back(typed ? want : predicted);
      items_sent++;
      if (predicted.mem_write) n_mem_wr++;
      if (it.mode == MODE_LOAD) begin
         n_load++;
         if (it.reg_index == MEM_SLOT) n_flag_load++;
      end else begin
         case (group_type'(it.opcode[7:6]))
            GRP_SHIFT: n_shift++;
            GRP_BIT:   n_bit++;
            GRP_RES:   n_res++;
            default:   n_set++;
         endcase
      end
   endtask

   task automatic report_mismatch(string what, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("%0t: %s: expected value %h flags %b wr %b, got value %h flags %b wr %b",
                  $realtime, what, want.result_value, want.flag_bits, want.mem_write,
                  got.result_value, got.flag_bits, got.mem_write);
   endtask

   // Check each result taken and drive the result-side stall
   always @(posedge clock) begin : rsp_side
      rsp_type want_rsp;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", '0, rsp_payload);
         end else begin
            want_rsp = pending_results.pop_front();
            if (rsp_payload.result_value !== want_rsp.result_value ||
                rsp_payload.flag_bits !== want_rsp.flag_bits ||
                rsp_payload.mem_write !== want_rsp.mem_write)
               report_mismatch("result mismatch", want_rsp, rsp_payload);
         end
      end
      if (reset) rsp_stall <= 1'b0;
      else if (hold_active) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // Hold off the result side for a long stretch so the block backs up
   initial begin
      wait (items_sent >= HOLD_AT);
      @(posedge clock);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   // Abort a run that hangs
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Main sequence: reset, directed rows, three random phases, drain
   initial begin
      for (int i = 0; i < REG_DEPTH; i++) shadow_regs[i] = '0;
      shadow_flags = '0;

      directed_rows = '{
         '{exec_item(cb_op(GRP_SHIFT, SH_RLC, REG_B), 8'h00), 1'b1, '{8'h00, 4'b1000, 1'b0}},
         '{exec_item(cb_op(GRP_BIT, 3'd7, REG_A), 8'h00),     1'b1, '{8'h00, 4'b1010, 1'b0}},
         '{load_item(REG_A, 8'hFF),                           1'b1, '{8'hFF, 4'b1010, 1'b0}},
         '{load_item(MEM_SLOT, 8'hF0),                        1'b1, '{8'hF0, 4'b1111, 1'b0}},
         '{exec_item(cb_op(GRP_SHIFT, SH_RL, REG_A), 8'h00),  1'b0, '0},
         '{load_item(REG_B, 8'h80),                           1'b0, '0},
         '{exec_item(cb_op(GRP_SHIFT, SH_RLC, REG_B), 8'h00), 1'b0, '0},
         '{exec_item(cb_op(GRP_SHIFT, SH_RRC, REG_C), 8'h00), 1'b0, '0},
         '{exec_item(cb_op(GRP_SHIFT, SH_RL, MEM_SLOT), 8'h80), 1'b0, '0},
         '{exec_item(cb_op(GRP_SHIFT, SH_RR, MEM_SLOT), 8'h01), 1'b0, '0},
         '{exec_item(cb_op(GRP_SHIFT, SH_SLA, REG_D), 8'h00),   1'b0, '0},
         '{exec_item(cb_op(GRP_SHIFT, SH_SRA, MEM_SLOT), 8'h81), 1'b0, '0},
         '{exec_item(cb_op(GRP_SHIFT, SH_SWAP, MEM_SLOT), 8'hF0), 1'b1,
           '{8'h0F, 4'b0000, 1'b1}},
         '{exec_item(cb_op(GRP_SHIFT, SH_SRL, MEM_SLOT), 8'h01), 1'b1,
           '{8'h00, 4'b1001, 1'b1}},
         '{exec_item(cb_op(GRP_BIT, 3'd0, MEM_SLOT), 8'hFE), 1'b1, '{8'hFE, 4'b1011, 1'b0}},
         '{exec_item(cb_op(GRP_RES, 3'd7, MEM_SLOT), 8'hFF), 1'b1, '{8'h7F, 4'b1011, 1'b1}},
         '{exec_item(cb_op(GRP_SET, 3'd0, MEM_SLOT), 8'h00), 1'b1, '{8'h01, 4'b1011, 1'b1}},
         '{exec_item(cb_op(GRP_SET, 3'd7, REG_A), 8'h00),    1'b0, '0},
         '{exec_item(cb_op(GRP_RES, 3'd0, REG_A), 8'h00),    1'b0, '0},
         '{load_item(REG_H, 8'h5A),                          1'b0, '0},
         '{load_item(REG_L, 8'hA5),                          1'b0, '0},
         '{exec_item(cb_op(GRP_BIT, 3'd3, REG_L), 8'h00),    1'b0, '0},
         '{exec_item(cb_op(GRP_SHIFT, SH_SWAP, REG_H), 8'h00), 1'b0, '0},
         // flag load with every ignored field at its top value
         '{'{MODE_LOAD, cb_op(GRP_SET, 3'd7, REG_A), 8'hFF, MEM_SLOT, 8'h00}, 1'b1,
           '{8'h00, 4'b0000, 1'b0}},
         '{'{MODE_EXEC, cb_op(GRP_SHIFT, SH_SRA, REG_E), 8'hFF, REG_A, 8'hFF}, 1'b0, '0}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 16; rsp_idle_pct = 63; end
            1: begin sender_idle_pct = 63; rsp_idle_pct = 16; end
            default: begin sender_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) offer_item(random_item(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      // Wait for every result, then keep clocking for strays
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d items: %0d shift/rotate, %0d BIT, %0d RES, %0d SET, %0d loads (%0d flags)",
               items_sent, n_shift, n_bit, n_res, n_set, n_load, n_flag_load);
      $display("Checked %0d results, %0d memory write-backs, %0d mismatches",
               results_checked, n_mem_wr, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
